FILE: hdl/sfr_pkg.sv
// shared constants and types for the serial frame receiver
package sfr_pkg;

    // frame layout
    localparam int unsigned PayloadBytes = 7;
    localparam logic [7:0]  HdrFirst     = 8'hAA;
    localparam logic [7:0]  HdrSecond    = 8'hC0;
    localparam logic [7:0]  EndByte      = 8'hAB;

    // store keeps at least the six bytes that the result fields read
    localparam int unsigned StoreDepth   = (PayloadBytes > 6) ? PayloadBytes : 6;
    localparam int unsigned IdxW         = $clog2(StoreDepth);
    localparam int unsigned CountW       = $clog2(PayloadBytes + 1);

    // payload positions of the result fields
    localparam int unsigned PosIdHigh    = 0;
    localparam int unsigned PosIdLow     = 1;
    localparam int unsigned PosStateOne  = 2;
    localparam int unsigned PosStateTwo  = 3;
    localparam int unsigned PosStateThree = 4;
    localparam int unsigned PosReserved  = 5;

    // decoded frame, packed with device_id in the lowest bits
    typedef struct packed {
        logic [7:0]  reserved_byte;
        logic [7:0]  state_three;
        logic [7:0]  state_two;
        logic [7:0]  state_one;
        logic [15:0] device_id;
    } t_result;

endpackage

FILE: hdl/sfr_deframe.sv
// frame hunt state machine, payload store and running checksum
module sfr_deframe (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,        // consume i_rx_byte this cycle
    input  logic [7:0]          i_rx_byte,
    output logic                o_res_valid,
    output sfr_pkg::t_result    o_res
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_GOT_AA  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [sfr_pkg::CountW-1:0] LastCount =
        sfr_pkg::CountW'(sfr_pkg::PayloadBytes);
    localparam logic [sfr_pkg::CountW-1:0] SumCount =
        sfr_pkg::CountW'(sfr_pkg::PayloadBytes - 1);

    // store positions read at fixed places
    localparam logic [sfr_pkg::IdxW-1:0] IdxCheck =
        sfr_pkg::IdxW'(sfr_pkg::PayloadBytes - 1);
    localparam logic [sfr_pkg::IdxW-1:0] IdxIdHigh =
        sfr_pkg::IdxW'(sfr_pkg::PosIdHigh);
    localparam logic [sfr_pkg::IdxW-1:0] IdxIdLow =
        sfr_pkg::IdxW'(sfr_pkg::PosIdLow);
    localparam logic [sfr_pkg::IdxW-1:0] IdxStateOne =
        sfr_pkg::IdxW'(sfr_pkg::PosStateOne);
    localparam logic [sfr_pkg::IdxW-1:0] IdxStateTwo =
        sfr_pkg::IdxW'(sfr_pkg::PosStateTwo);
    localparam logic [sfr_pkg::IdxW-1:0] IdxStateThree =
        sfr_pkg::IdxW'(sfr_pkg::PosStateThree);
    localparam logic [sfr_pkg::IdxW-1:0] IdxReserved =
        sfr_pkg::IdxW'(sfr_pkg::PosReserved);

    logic [1:0]                  r_phase, n_phase;
    logic [sfr_pkg::CountW-1:0]  r_count, n_count;
    logic [7:0]                  r_sum, n_sum;
    logic [7:0]                  r_store [sfr_pkg::StoreDepth];
    logic                        w_store_en;
    logic [sfr_pkg::IdxW-1:0]    w_store_idx;

    // next state
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_sum       = r_sum;
        w_store_en  = 1'b0;
        w_store_idx = sfr_pkg::IdxW'(r_count);
        o_res_valid = 1'b0;
        case (r_phase)
            PH_GOT_AA: begin
                if (i_rx_byte == sfr_pkg::HdrSecond) begin
                    n_phase = PH_PAYLOAD;
                    n_count = '0;
                end
            end
            PH_PAYLOAD: begin
                if (r_count != LastCount) begin
                    w_store_en = 1'b1;
                    n_count    = r_count + 1'b1;
                    // checksum covers all payload bytes but the last
                    if (r_count == '0) begin
                        n_sum = i_rx_byte;
                    end else if (r_count < SumCount) begin
                        n_sum = r_sum + i_rx_byte;
                    end
                end else begin
                    n_phase     = PH_HUNT;
                    n_count     = '0;
                    o_res_valid = (i_rx_byte == sfr_pkg::EndByte) &&
                                  (r_sum == r_store[IdxCheck]);
                end
            end
            default: begin
                // hunting, unused code acts the same
                n_phase = (i_rx_byte == sfr_pkg::HdrFirst) ? PH_GOT_AA : PH_HUNT;
                n_count = '0;
            end
        endcase
        if (!i_en) begin
            o_res_valid = 1'b0;
        end
    end

    // result fields; bytes past the payload length read as zero
    always_comb begin
        o_res = '0;
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosIdHigh) begin
            o_res.device_id[15:8] = r_store[IdxIdHigh];
        end
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosIdLow) begin
            o_res.device_id[7:0] = r_store[IdxIdLow];
        end
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosStateOne) begin
            o_res.state_one = r_store[IdxStateOne];
        end
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosStateTwo) begin
            o_res.state_two = r_store[IdxStateTwo];
        end
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosStateThree) begin
            o_res.state_three = r_store[IdxStateThree];
        end
        if (sfr_pkg::PayloadBytes > sfr_pkg::PosReserved) begin
            o_res.reserved_byte = r_store[IdxReserved];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_count <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // checksum and payload store
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
            if (w_store_en) begin
                r_store[w_store_idx] <= i_rx_byte;
            end
        end
    end

endmodule

FILE: hdl/sfr_out_buf.sv
// result register with skid stage toward the output stream
module sfr_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfr_pkg::t_result    i_data,
    output logic                o_ready,     // room for one more item
    output logic                o_valid,
    input  logic                i_ready,
    output sfr_pkg::t_result    o_data
);

    logic             r_main_valid, n_main_valid;
    logic             r_skid_valid, n_skid_valid;
    sfr_pkg::t_result r_main, n_main;
    sfr_pkg::t_result r_skid, n_skid;
    logic             w_pop;

    assign w_pop   = r_main_valid && i_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    // move items between main and skid registers
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_data;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

endmodule

FILE: hdl/serial_frame_receiver.sv
// serial frame receiver top level: input register, deframer, output buffer
//
//  channel   direction  tdata fields (low bit up)
//  s_axis    in         rx_byte[7:0]
//  m_axis    out        device_id[15:0], state_one, state_two, state_three,
//                       reserved_byte (8 bit each, 48 bits total)
//
// one byte per cycle while the output buffer has room; a byte waits in the input
// register for the deframer, and a result is registered in the output buffer
// reset (i_rst_n low, synchronous) returns to hunting and empties both stages
// the output has a skid register, so s_axis keeps flowing while a result waits;
// s_axis_tready drops only once two results are queued and m_axis is stalled
module serial_frame_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // device_id, state_one, state_two,
                                        // state_three, reserved_byte
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             w_buf_ready;
    logic             w_consume;
    logic             w_res_valid;
    sfr_pkg::t_result w_res;
    sfr_pkg::t_result w_out;

    assign w_consume     = r_in_valid && w_buf_ready;
    assign s_axis_tready = !r_in_valid || w_buf_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfr_deframe u_deframe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_consume),
        .i_rx_byte   (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sfr_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = w_out;

endmodule

FILE: tb/sv/serial_frame_receiver_tb.sv
// self-checking testbench for the serial frame receiver
`timescale 1ns / 100ps

module serial_frame_receiver_tb;

    localparam int unsigned IdleMax       = 12;
    localparam int unsigned LongStallAt   = 12;
    localparam int unsigned LongStall     = 500;
    localparam int unsigned WatchdogLimit = 4000;
    localparam int unsigned RandomItems   = 1000;
    localparam int unsigned TailCycles    = 20;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT_AA,
        PH_PAYLOAD
    } t_rx_phase;

    typedef struct {
        logic [7:0] data;
        bit         drain;
    } t_tx_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // rx_byte[7:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // device_id, state_one, state_two,
                                          // state_three, reserved_byte

    // bytes waiting to be sent and decoded frames waiting to come out
    t_tx_item          tx_q[$];
    sfr_pkg::t_result  frame_q[$];
    bit                drain_next = 1'b0;

    // shadow deframer state
    t_rx_phase   rx_phase = PH_HUNT;
    int unsigned pay_cnt  = 0;
    logic [7:0]  pay_buf [sfr_pkg::PayloadBytes];

    int unsigned mismatches   = 0;
    int unsigned sent_items   = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap     = 0;
    int unsigned ready_wait   = 0;
    int unsigned stall_draw;
    int unsigned idle_cycles  = 0;
    bit          tx_burst     = 1'b0;
    bit          rx_burst     = 1'b0;
    t_tx_item         tx_next;
    sfr_pkg::t_result want_frame;
    sfr_pkg::t_result got_frame;

    serial_frame_receiver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // payload byte at position k, zero when the payload is too short for it
    function automatic logic [7:0] pay_at(int unsigned k);
        return (k < sfr_pkg::PayloadBytes) ? pay_buf[k] : 8'h00;
    endfunction

    // advance the shadow deframer by one byte, queue a frame when one completes
    function automatic void deframe_byte(logic [7:0] b);
        logic [7:0]       sum;
        sfr_pkg::t_result r;
        sum = 8'h00;
        case (rx_phase)
            PH_GOT_AA: begin
                if (b == sfr_pkg::HdrSecond) begin
                    rx_phase = PH_PAYLOAD;
                    pay_cnt  = 0;
                end
            end
            PH_PAYLOAD: begin
                if (pay_cnt < sfr_pkg::PayloadBytes) begin
                    pay_buf[pay_cnt] = b;
                    pay_cnt++;
                end else begin
                    rx_phase = PH_HUNT;
                    pay_cnt  = 0;
                    if (b == sfr_pkg::EndByte) begin
                        for (int unsigned k = 0; k + 1 < sfr_pkg::PayloadBytes; k++)
                            sum = sum + pay_buf[k];
                        if (sum == pay_at(sfr_pkg::PayloadBytes - 1)) begin
                            r.device_id     = {pay_at(sfr_pkg::PosIdHigh),
                                               pay_at(sfr_pkg::PosIdLow)};
                            r.state_one     = pay_at(sfr_pkg::PosStateOne);
                            r.state_two     = pay_at(sfr_pkg::PosStateTwo);
                            r.state_three   = pay_at(sfr_pkg::PosStateThree);
                            r.reserved_byte = pay_at(sfr_pkg::PosReserved);
                            frame_q.push_back(r);
                        end
                    end
                end
            end
            default: begin
                // hunting
                rx_phase = (b == sfr_pkg::HdrFirst) ? PH_GOT_AA : PH_HUNT;
                pay_cnt  = 0;
            end
        endcase
    endfunction

    task automatic push_byte(logic [7:0] b);
        t_tx_item it;
        it.data  = b;
        it.drain = drain_next;
        drain_next = 1'b0;
        tx_q.push_back(it);
    endtask

    // one frame with random content, optional noise, bad checksum or bad end byte
    task automatic push_frame(bit good_sum, bit good_end);
        logic [7:0] sum;
        logic [7:0] b;
        int unsigned n;
        sum = 8'h00;
        n = $urandom_range(0, 2);
        repeat (n) push_byte(8'($urandom_range(0, 255)));
        push_byte(sfr_pkg::HdrFirst);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) begin
            b = 8'($urandom_range(0, 255));
            if (b == sfr_pkg::HdrSecond)
                b = 8'h00;
            push_byte(b);
        end
        push_byte(sfr_pkg::HdrSecond);
        for (int unsigned k = 0; k + 1 < sfr_pkg::PayloadBytes; k++) begin
            if (k >= sfr_pkg::PosStateOne && k <= sfr_pkg::PosStateThree &&
                $urandom_range(0, 2) != 0)
                b = 8'($urandom_range(0, 2));
            else
                b = 8'($urandom_range(0, 255));
            sum = sum + b;
            push_byte(b);
        end
        push_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
        b = 8'($urandom_range(0, 255));
        if (b == sfr_pkg::EndByte)
            b = ~b;
        push_byte(good_end ? sfr_pkg::EndByte : b);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // sender: one item per handshake, random gaps, optional wait for an empty pipe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (send_gap > 0) begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end else if (tx_q.size() > 0 &&
                         !(tx_q[0].drain && (s_axis_tvalid || frame_q.size() != 0))) begin
                tx_next = tx_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tx_next.data;
                sent_items++;
                if (sent_items % 50 == 0)
                    tx_burst = ($urandom_range(0, 2) == 0);
                send_gap <= tx_burst ? 0 : $urandom_range(0, IdleMax);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor: predict from accepted bytes, check accepted frames, pace tready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            ready_wait    <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                deframe_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                got_frame = sfr_pkg::t_result'(m_axis_tdata);
                if (frame_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected frame %h", $realtime, m_axis_tdata);
                end else begin
                    want_frame = frame_q.pop_front();
                    check_field("device_id", want_frame.device_id, got_frame.device_id);
                    check_field("state_one", 16'(want_frame.state_one),
                                16'(got_frame.state_one));
                    check_field("state_two", 16'(want_frame.state_two),
                                16'(got_frame.state_two));
                    check_field("state_three", 16'(want_frame.state_three),
                                16'(got_frame.state_three));
                    check_field("reserved_byte", 16'(want_frame.reserved_byte),
                                16'(got_frame.reserved_byte));
                end
                results_seen++;
                if (results_seen % 16 == 0)
                    rx_burst = ($urandom_range(0, 2) == 0);
                // one long hold-off so the output buffer fills and input stalls
                if (results_seen == LongStallAt)
                    stall_draw = LongStall;
                else
                    stall_draw = rx_burst ? 0 : $urandom_range(0, IdleMax);
                m_axis_tready <= (stall_draw == 0);
                ready_wait    <= stall_draw;
            end else if (ready_wait > 0) begin
                m_axis_tready <= (ready_wait == 1);
                ready_wait    <= ready_wait - 1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WatchdogLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus and end of run
    initial begin
        int unsigned pick;
        int unsigned n;

        // max payload, header byte repeated and noise while waiting for the second header
        push_byte(sfr_pkg::HdrFirst);
        push_byte(8'h12);
        push_byte(sfr_pkg::HdrFirst);
        push_byte(sfr_pkg::HdrSecond);
        for (int unsigned k = 0; k + 1 < sfr_pkg::PayloadBytes; k++)
            push_byte(8'hFF);
        push_byte(8'(8'hFF * (sfr_pkg::PayloadBytes - 1)));
        push_byte(sfr_pkg::EndByte);
        // all-zero payload
        push_byte(sfr_pkg::HdrFirst);
        push_byte(sfr_pkg::HdrSecond);
        repeat (sfr_pkg::PayloadBytes) push_byte(8'h00);
        push_byte(sfr_pkg::EndByte);
        // stray end byte while hunting
        push_byte(sfr_pkg::EndByte);

        // random part: mostly frames, some noise, pauses for an empty pipe at the start and near the middle
        drain_next = 1'b1;
        n = tx_q.size();
        while (tx_q.size() < n + RandomItems) begin
            if (tx_q.size() >= n + RandomItems / 2 && tx_q.size() < n + RandomItems / 2 + 12)
                drain_next = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 85)
                push_frame($urandom_range(0, 99) < 80, $urandom_range(0, 99) < 85);
            else
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom_range(0, 255)));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (tx_q.size() == 0 && !s_axis_tvalid);
        wait (frame_q.size() == 0);
        repeat (TailCycles) @(posedge i_clk);
        if (mismatches == 0 && frame_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
